### rtl/hdlcd_pkg.sv
package hdlcd_pkg;

    localparam logic [7:0]  FLAG_PATTERN    = 8'h7E;
    localparam logic [2:0]  STUFF_RUN       = 3'd5;
    localparam logic [2:0]  ONES_MAX        = 3'd7;
    localparam logic [3:0]  BYTE_BITS       = 4'd8;
    localparam logic [9:0]  MIN_FRAME_RESET = 10'd18;
    localparam logic [9:0]  CAPACITY_RESET  = 10'd512;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h8408;

    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_GOOD  = 3'd1;
    localparam logic [2:0] ST_SMALL = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_LONG  = 3'd4;

    localparam logic REG_MIN_FRAME = 1'b0;
    localparam logic REG_CAPACITY  = 1'b1;

    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_data;
        logic [2:0]  status;
        logic [8:0]  len;
        logic [15:0] fcs;
    } t_line_res;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/hdlc_nrzi_bit_deframer_top.sv
// An accepted beat reaches o_valid through two register stages: s1, then the output register.
// Throughput: one item per cycle while o_stall is low, line level or store read
// alike; the frame store has one write port and one registered read port.
// Reset: synchronous, active low; clears the deframer state, loads the
// register defaults, and leaves the frame store contents unknown.
module hdlc_nrzi_bit_deframer_top #(
    parameter int STORE_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic        i_line_level,
    input  logic [8:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [8:0]  o_frame_length,
    output logic [15:0] o_fcs,
    output logic [7:0]  o_read_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hdlcd_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rd_data;
    logic [9:0]    r_min_frame;
    logic [9:0]    r_capacity;

    logic          r_s1_valid;
    logic          r_s1_rd;
    logic [2:0]    r_s1_status;
    logic [8:0]    r_s1_len;
    logic [15:0]   r_s1_fcs;

    logic          r_o_valid;
    logic [2:0]    r_o_status;
    logic [8:0]    r_o_len;
    logic [15:0]   r_o_fcs;
    logic [7:0]    r_o_byte;

    logic          w_out_free;
    logic          w_accept;
    logic          w_step;
    logic          w_in_range;
    logic [AW-1:0] w_wr_addr;
    t_line_res     w_res;

    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign w_step     = w_accept && !i_kind;
    assign w_in_range = 32'(i_read_index) < STORE_BYTES;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {22'd0, r_capacity} : {22'd0, r_min_frame};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frame <= MIN_FRAME_RESET;
            r_capacity  <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MIN_FRAME) begin
                r_min_frame <= pwdata[9:0];
            end else begin
                r_capacity <= pwdata[9:0];
            end
        end
    end

    hdlcd_line #(
        .STORE_BYTES(STORE_BYTES)
    ) u_line (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_step),
        .i_line_level      (i_line_level),
        .i_min_frame_bytes (r_min_frame),
        .i_output_capacity (r_capacity),
        .o_wr_addr         (w_wr_addr),
        .o_res             (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.wr_en) begin
            r_mem[w_wr_addr] <= w_res.wr_data;
        end
        if (w_accept && i_kind) begin
            r_rd_data <= r_mem[AW'(i_read_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rd     <= i_kind && w_in_range;
            r_s1_status <= i_kind ? ST_NONE : w_res.status;
            r_s1_len    <= i_kind ? 9'd0 : w_res.len;
            r_s1_fcs    <= i_kind ? 16'h0000 : w_res.fcs;
        end
        if (w_out_free) begin
            r_o_status <= r_s1_status;
            r_o_len    <= r_s1_len;
            r_o_fcs    <= r_s1_fcs;
            r_o_byte   <= r_s1_rd ? r_rd_data : 8'h00;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_frame_length = r_o_len;
    assign o_fcs          = r_o_fcs;
    assign o_read_byte    = r_o_byte;

endmodule

### rtl/hdlcd_line.sv
module hdlcd_line #(
    parameter int STORE_BYTES = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_line_level,
    input  logic [9:0]                        i_min_frame_bytes,
    input  logic [9:0]                        i_output_capacity,
    output logic [$clog2(STORE_BYTES)-1:0]    o_wr_addr,
    output hdlcd_pkg::t_line_res              o_res
);
    import hdlcd_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int LW = (CW > 10) ? CW : 10;

    logic          r_last_level;
    logic [7:0]    r_window;
    logic [7:0]    r_shift;
    logic [3:0]    r_bits;
    logic [2:0]    r_ones;
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [7:0]    r_b1;
    logic [7:0]    r_b2;

    logic [7:0]    n_window;
    logic [7:0]    n_shift;
    logic [3:0]    n_bits;
    logic [2:0]    n_ones;
    logic [CW-1:0] n_count;
    logic [15:0]   n_crc;
    logic [7:0]    n_b1;
    logic [7:0]    n_b2;

    logic          w_bit;
    logic [7:0]    w_win;
    logic [CW-1:0] w_len;

    assign w_bit = (i_line_level == r_last_level);
    assign w_win = {r_window[6:0], w_bit};
    assign w_len = r_count - CW'(2);

    always_comb begin
        n_window      = w_win;
        n_shift       = r_shift;
        n_bits        = r_bits;
        n_ones        = r_ones;
        n_count       = r_count;
        n_crc         = r_crc;
        n_b1          = r_b1;
        n_b2          = r_b2;
        o_wr_addr     = AW'(r_count);
        o_res.wr_en   = 1'b0;
        o_res.wr_data = 8'h00;
        o_res.status  = ST_NONE;
        o_res.len     = 9'd0;
        o_res.fcs     = 16'h0000;
        if (w_win == FLAG_PATTERN) begin
            if (r_count > CW'(2)) begin
                if (LW'(w_len) < LW'(i_min_frame_bytes)) begin
                    o_res.status = ST_SMALL;
                end else if (LW'(w_len) > LW'(i_output_capacity)) begin
                    o_res.status = ST_LONG;
                end else if (~r_crc == {r_b1, r_b2}) begin
                    o_res.status = ST_GOOD;
                    o_res.len    = 9'(w_len);
                    o_res.fcs    = {r_b1, r_b2};
                end else begin
                    o_res.status = ST_BAD;
                end
            end
            n_window = 8'h00;
            n_shift  = 8'h00;
            n_bits   = 4'd0;
            n_ones   = 3'd0;
            n_count  = '0;
            n_crc    = CRC_INIT;
        end else begin
            if (w_bit) begin
                n_shift = {1'b1, r_shift[7:1]};
                n_bits  = r_bits + 4'd1;
                if (r_ones != ONES_MAX) begin
                    n_ones = r_ones + 3'd1;
                end
            end else begin
                if (r_ones < STUFF_RUN) begin
                    n_shift = {1'b0, r_shift[7:1]};
                    n_bits  = r_bits + 4'd1;
                end
                n_ones = 3'd0;
            end
            if (n_bits == BYTE_BITS) begin
                o_res.wr_en = 1'b1;
                n_bits      = 4'd0;
                if (r_count >= CW'(STORE_BYTES)) begin
                    o_wr_addr     = '0;
                    o_res.wr_data = 8'h00;
                    n_window      = 8'h00;
                    n_shift       = 8'h00;
                    n_ones        = 3'd0;
                    n_count       = CW'(1);
                    n_crc         = CRC_INIT;
                    n_b1          = 8'h00;
                end else begin
                    o_res.wr_data = n_shift;
                    if (r_count >= CW'(2)) begin
                        n_crc = crc_fold(r_crc, r_b2);
                    end
                    n_count = r_count + CW'(1);
                    n_b2    = r_b1;
                    n_b1    = n_shift;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_window     <= 8'h00;
            r_shift      <= 8'h00;
            r_bits       <= 4'd0;
            r_ones       <= 3'd0;
            r_count      <= '0;
            r_crc        <= CRC_INIT;
        end else if (i_step) begin
            r_last_level <= i_line_level;
            r_window     <= n_window;
            r_shift      <= n_shift;
            r_bits       <= n_bits;
            r_ones       <= n_ones;
            r_count      <= n_count;
            r_crc        <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_b1 <= n_b1;
            r_b2 <= n_b2;
        end
    end

endmodule

### tb/sv/hdlc_nrzi_bit_deframer_checker.sv
package hdlcd_tb_pkg;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    function automatic logic [15:0] x25_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ hdlcd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

module hdlc_nrzi_bit_deframer_checker #(
    parameter int STORE_BYTES = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   o_stall,
    input  logic                   i_kind,
    input  logic                   i_line_level,
    input  logic [8:0]             i_read_index,
    input  logic                   o_valid,
    input  logic                   i_stall,
    input  logic [2:0]             o_status,
    input  logic [8:0]             o_frame_length,
    input  logic [15:0]            o_fcs,
    input  logic [7:0]             o_read_byte,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    output int                     o_mismatches,
    output int                     o_pending,
    output logic [STORE_BYTES-1:0] o_written
);
    timeunit 1ns;
    timeprecision 1ps;

    import hdlcd_pkg::*;
    import hdlcd_tb_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  length;
        logic [15:0] fcs;
        logic [7:0]  rd_byte;
    } frame_report_t;

    frame_report_t expected_q[$];

    logic [7:0]  store [STORE_BYTES];
    logic [9:0]  min_len;
    logic [9:0]  cap_len;
    logic        last_level;
    logic [7:0]  window;
    logic [7:0]  shreg;
    logic [3:0]  nbits;
    logic [2:0]  ones_run;
    logic [9:0]  byte_count;
    logic [15:0] crc;

    function automatic void restart_frame();
        window     = '0;
        shreg      = '0;
        nbits      = '0;
        ones_run   = '0;
        byte_count = '0;
        crc        = CRC_INIT;
    endfunction

    function automatic void shift_data_bit(input logic b);
        if (b) begin
            shreg = {1'b1, shreg[7:1]};
            nbits++;
            if (ones_run != ONES_MAX) begin
                ones_run++;
            end
        end else begin
            if (ones_run < STUFF_RUN) begin
                shreg = {1'b0, shreg[7:1]};
                nbits++;
            end
            ones_run = '0;
        end
        if (nbits == BYTE_BITS) begin
            if (byte_count >= STORE_BYTES) begin
                restart_frame();
            end
            store[AW'(byte_count)] = shreg;
            o_written[AW'(byte_count)] = 1'b1;
            if (byte_count >= 2) begin
                crc = x25_fold(crc, store[AW'(byte_count - 10'd2)]);
            end
            byte_count++;
            nbits = '0;
        end
    endfunction

    function automatic frame_report_t deframe_step(input logic kind, input logic lvl,
                                                   input logic [8:0] idx);
        frame_report_t r;
        logic          b;
        logic [9:0]    plen;
        logic [15:0]   rx_fcs;
        r = '0;
        r.status = ST_NONE;
        if (kind == KIND_READ) begin
            r.rd_byte = store[AW'(idx)];
        end else begin
            b = (lvl == last_level);
            last_level = lvl;
            window = {window[6:0], b};
            if (window == FLAG_PATTERN) begin
                if (byte_count > 10'd2) begin
                    plen = byte_count - 10'd2;
                    if (plen < min_len) begin
                        r.status = ST_SMALL;
                    end else if (plen > cap_len) begin
                        r.status = ST_LONG;
                    end else begin
                        rx_fcs = {store[AW'(plen + 10'd1)], store[AW'(plen)]};
                        if ((crc ^ 16'hFFFF) == rx_fcs) begin
                            r.status = ST_GOOD;
                            r.length = plen[8:0];
                            r.fcs    = rx_fcs;
                        end else begin
                            r.status = ST_BAD;
                        end
                    end
                end
                restart_frame();
            end else begin
                shift_data_bit(b);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_mismatches < 100) begin
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        frame_report_t want;
        if (!i_rst_n) begin
            min_len      = MIN_FRAME_RESET;
            cap_len      = CAPACITY_RESET;
            last_level   = 1'b0;
            restart_frame();
            expected_q.delete();
            o_mismatches = 0;
            o_written    = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_MIN_FRAME: min_len = pwdata[9:0];
                    REG_CAPACITY:  cap_len = pwdata[9:0];
                endcase
            end
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("status of a result with no beat waiting",
                                    32'(o_status), 32'(ST_NONE));
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    end
                    if (o_frame_length !== want.length) begin
                        report_mismatch("frame_length", 32'(o_frame_length),
                                        32'(want.length));
                    end
                    if (o_fcs !== want.fcs) begin
                        report_mismatch("fcs", 32'(o_fcs), 32'(want.fcs));
                    end
                    if (o_read_byte !== want.rd_byte) begin
                        report_mismatch("read_byte", 32'(o_read_byte), 32'(want.rd_byte));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                expected_q.push_back(deframe_step(i_kind, i_line_level, i_read_index));
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

### tb/sv/hdlc_nrzi_bit_deframer_top_tb.sv
module hdlc_nrzi_bit_deframer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdlcd_pkg::*;
    import hdlcd_tb_pkg::*;

    localparam int STORE_BYTES    = 512;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BEATS    = 60;

    typedef logic [7:0] byte_q_t[$];
    typedef enum {FR_GOOD, FR_BAD_FCS, FR_ABORT} frame_shape_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = KIND_LINE;
    logic        i_line_level = 1'b0;
    logic [8:0]  i_read_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [8:0]  o_frame_length;
    logic [15:0] o_fcs;
    logic [7:0]  o_read_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int                     mismatches;
    int                     pending;
    logic [STORE_BYTES-1:0] written;

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   hold_cycles = 0;
    int   read_pct = 0;
    int   idle_run = 0;
    int   line_beats = 0;
    int   tx_ones = 0;
    logic tx_level = 1'b0;

    always #5 i_clk = ~i_clk;

    hdlc_nrzi_bit_deframer_top #(.STORE_BYTES(STORE_BYTES)) dut (.*);

    hdlc_nrzi_bit_deframer_checker #(.STORE_BYTES(STORE_BYTES)) deframe_check (
        .o_mismatches(mismatches),
        .o_pending(pending),
        .o_written(written),
        .*
    );

    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_run <= 0;
        end else if (idle_run == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    task automatic push_beat(input logic kind, input logic lvl, input logic [8:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_line_level <= lvl;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_level(input logic lvl);
        logic [8:0] idx;
        idx = 9'($urandom_range(511));
        if ($urandom_range(99) < read_pct) begin
            repeat (8) begin
                if (!written[idx]) begin
                    idx = $urandom_range(1) ? 9'($urandom_range(31)) : 9'($urandom_range(511));
                end
            end
            if (written[idx]) begin
                push_beat(KIND_READ, 1'($urandom_range(1)), idx);
            end
            idx = 9'($urandom_range(511));
        end
        push_beat(KIND_LINE, lvl, idx);
        tx_level = lvl;
        line_beats++;
    endtask

    task automatic send_bit(input logic b);
        send_level(b ? tx_level : ~tx_level);
    endtask

    task automatic send_data_bit(input logic b);
        send_bit(b);
        if (b) begin
            tx_ones++;
            if (tx_ones == STUFF_RUN) begin
                send_bit(1'b0);
                tx_ones = 0;
            end
        end else begin
            tx_ones = 0;
        end
    endtask

    task automatic send_byte(input logic [7:0] value);
        for (int i = 0; i < 8; i++) begin
            send_data_bit(value[i]);
        end
    endtask

    task automatic send_flag();
        for (int i = 0; i < 8; i++) begin
            send_bit(FLAG_PATTERN[i]);
        end
        tx_ones = 0;
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_level(1'($urandom_range(1)));
        tx_ones = 0;
    endtask

    task automatic send_frame(input byte_q_t payload, input frame_shape_e shape);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (payload[i]) begin
            crc = x25_fold(crc, payload[i]);
        end
        crc = ~crc;
        if (shape == FR_BAD_FCS) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        foreach (payload[i]) begin
            send_byte(payload[i]);
            if (shape == FR_ABORT && i == payload.size() / 2) begin
                repeat ($urandom_range(7, 9)) send_bit(1'b1);
                tx_ones = 0;
            end
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        send_flag();
    endtask

    function automatic byte_q_t random_payload(input int n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int phase_min;
        int phase_cap;
        int len_lo;
        int len_hi;
        int target;
        int pick;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_flag();
        send_flag();
        send_frame(random_payload(0), FR_GOOD);
        send_frame(random_payload(1), FR_GOOD);
        push_beat(KIND_READ, 1'b0, 9'd0);
        push_beat(KIND_READ, 1'b1, 9'd2);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    phase_min = 18; phase_cap = 512; len_lo = 14; len_hi = 24;
                    tx_idle_pct = 0; rx_stall_pct = 0;
                end
                1: begin
                    phase_min = 0; phase_cap = 512; len_lo = 0; len_hi = 12;
                    tx_idle_pct = 83; rx_stall_pct = 0;
                end
                2: begin
                    phase_min = 3; phase_cap = 6; len_lo = 0; len_hi = 9;
                    tx_idle_pct = 0; rx_stall_pct = 83;
                end
                3: begin
                    phase_min = 512; phase_cap = 0; len_lo = 0; len_hi = 8;
                    tx_idle_pct = 19; rx_stall_pct = 19;
                end
                4: begin
                    phase_min = 0; phase_cap = 0; len_lo = 0; len_hi = 6;
                    tx_idle_pct = 0; rx_stall_pct = 0;
                end
                default: begin
                    phase_min = 2; phase_cap = 10; len_lo = 0; len_hi = 14;
                    tx_idle_pct = 19; rx_stall_pct = 19;
                end
            endcase
            write_reg(REG_MIN_FRAME, phase_min[9:0]);
            write_reg(REG_CAPACITY, phase_cap[9:0]);
            read_pct = 8;
            if (p == 4) begin
                hold_cycles = 300;
            end
            target = line_beats + PHASE_BEATS;
            while (line_beats < target) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_frame(random_payload($urandom_range(len_lo, len_hi)), FR_GOOD);
                end else if (pick < 80) begin
                    send_frame(random_payload($urandom_range(len_lo, len_hi)), FR_BAD_FCS);
                end else if (pick < 90) begin
                    send_frame(random_payload($urandom_range(len_lo, len_hi)), FR_ABORT);
                end else begin
                    send_noise($urandom_range(4, 40));
                    send_flag();
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
